>>> rtl/core/pdpd_pkg.sv
// Shared types and constants for the pixel detector packet decoder.
// No dependencies; used by pdpd_decode, pdpd_hist and the top level.
package pdpd_pkg;

  localparam logic [1:0] ACT_STREAM = 2'd0;
  localparam logic [1:0] ACT_BIN    = 2'd1;
  localparam logic [1:0] ACT_COUNT  = 2'd2;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_BIN   = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  localparam logic [11:0] CNT_HITS     = 12'd0;
  localparam logic [11:0] CNT_HEADERS  = 12'd1;
  localparam logic [11:0] CNT_TRIGGERS = 12'd2;
  localparam logic [11:0] CNT_CONTROLS = 12'd3;

  localparam logic [7:0] REG_ROI_X_ABOVE = 8'd0;
  localparam logic [7:0] REG_ROI_X_BELOW = 8'd1;
  localparam logic [7:0] REG_ROI_Y_ABOVE = 8'd2;
  localparam logic [7:0] REG_ROI_Y_BELOW = 8'd3;

  localparam logic [8:0] ROI_X_ABOVE_RST = 9'd250;
  localparam logic [8:0] ROI_X_BELOW_RST = 9'd425;
  localparam logic [8:0] ROI_Y_ABOVE_RST = 9'd125;
  localparam logic [8:0] ROI_Y_BELOW_RST = 9'd325;

  localparam logic [7:0] HDR_BYTE0   = 8'h54;
  localparam logic [7:0] HDR_BYTE1   = 8'h50;
  localparam logic [7:0] HDR_BYTE2   = 8'h58;
  localparam logic [3:0] TOP_PIXEL   = 4'hB;
  localparam logic [3:0] TOP_CONTROL = 4'h4;
  localparam logic [7:0] TOP_TRIGGER = 8'h6F;

  localparam logic [7:0] CHIP_SHIFT = 8'd0;
  localparam logic [7:0] CHIP_FLIP  = 8'd1;
  localparam logic [7:0] CHIP_MIRROR = 8'd2;

  typedef struct packed {
    logic        rd;
    logic        inc;
  } hist_req_t;

  typedef struct packed {
    logic        pixel;
    logic        trigger;
    logic        control;
    logic        header;
    logic        bin_ok;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [9:0]  tot;
    logic [13:0] toa;
    logic [3:0]  ftoa;
    logic [29:0] coarse;
    logic [30:0] flight;
    logic [29:0] trig_time;
    logic [12:0] chunk_len;
    logic [7:0]  chip;
  } dec_t;

endpackage

>>> rtl/core/pdpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module pdpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pdpd_decode.sv
// Field extraction for one readout word: word class, pixel fields, layout
// transform, flight time and region test. Depends on pdpd_pkg.
module pdpd_decode #(
  parameter int HIST_BINS = 4096
) (
  input  logic [63:0]                                     word,
  input  logic [7:0]                                      chip_number,
  input  logic [29:0]                                     last_trigger_time,
  input  logic [8:0]                                      roi_x_above,
  input  logic [8:0]                                      roi_x_below,
  input  logic [8:0]                                      roi_y_above,
  input  logic [8:0]                                      roi_y_below,
  output pdpd_pkg::dec_t                                  dec,
  output logic [((HIST_BINS > 1) ? $clog2(HIST_BINS) : 1)-1:0] bin_addr
);

  localparam int AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

  logic [15:0] pa;
  logic [7:0]  px;
  logic [7:0]  py;
  logic [29:0] coarse;
  logic [30:0] flight;
  logic [28:0] bin;
  logic        roi_ok;

  assign pa     = word[59:44];
  assign px     = {pa[15:9], pa[2]};
  assign py     = {pa[8:3], pa[1:0]};
  assign coarse = {word[15:0], word[43:30]};
  assign flight = {1'b0, coarse} - {1'b0, last_trigger_time};
  assign bin    = flight[30:2];
  assign bin_addr = bin[AW-1:0];

  assign roi_ok = ({1'b0, px} > roi_x_above) && ({1'b0, px} < roi_x_below) &&
                  ({1'b0, py} > roi_y_above) && ({1'b0, py} < roi_y_below);

  always_comb begin
    dec           = '0;
    dec.pixel     = (word[63:60] == pdpd_pkg::TOP_PIXEL);
    dec.trigger   = (word[63:56] == pdpd_pkg::TOP_TRIGGER);
    dec.control   = (word[63:60] == pdpd_pkg::TOP_CONTROL);
    dec.header    = (word[7:0] == pdpd_pkg::HDR_BYTE0) &&
                    (word[15:8] == pdpd_pkg::HDR_BYTE1) &&
                    (word[23:16] == pdpd_pkg::HDR_BYTE2);
    dec.bin_ok    = !flight[30] && roi_ok && (32'(bin) < 32'(HIST_BINS));
    dec.tot       = word[29:20];
    dec.toa       = word[43:30];
    dec.ftoa      = word[19:16];
    dec.coarse    = coarse;
    dec.flight    = flight;
    dec.trig_time = word[41:12];
    dec.chunk_len = word[63:51];
    dec.chip      = word[39:32];
    case (chip_number)
      pdpd_pkg::CHIP_SHIFT: begin
        dec.x = {1'b1, px};
        dec.y = {1'b0, py};
      end
      pdpd_pkg::CHIP_FLIP: begin
        dec.x = ~{1'b0, px};
        dec.y = ~{1'b0, py};
      end
      pdpd_pkg::CHIP_MIRROR: begin
        dec.x = {1'b0, ~px};
        dec.y = ~{1'b0, py};
      end
      default: begin
        dec.x = {1'b0, px};
        dec.y = {1'b0, py};
      end
    endcase
  end

endmodule

>>> rtl/core/pdpd_hist.sv
// Histogram bin memory: clearing pass after reset, read-modify-write with
// same-cycle write forwarding. Depends on pdpd_pkg and pdpd_ram.
module pdpd_hist #(
  parameter int HIST_BINS = 4096
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             acc,
  input  pdpd_pkg::hist_req_t                              req,
  input  logic [((HIST_BINS > 1) ? $clog2(HIST_BINS) : 1)-1:0] addr,
  input  logic                                             adv,
  output logic [31:0]                                      value,
  output logic                                             clr_busy
);

  localparam int AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic          rd_q;
  logic          inc_q;
  logic [AW-1:0] addr_q;
  logic          fwd_hit_q;
  logic [31:0]   fwd_data_q;
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  assign clr_busy = clr_active;
  assign value    = !rd_q ? 32'd0 : (fwd_hit_q ? fwd_data_q : rdata);
  assign we       = clr_active || (adv && inc_q);
  assign waddr    = clr_active ? clr_addr : addr_q;
  assign wdata    = clr_active ? 32'd0 : value + 32'd1;

  pdpd_ram #(
    .WIDTH(32),
    .DEPTH(HIST_BINS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (acc && req.rd),
    .raddr(addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      rd_q       <= 1'b0;
      inc_q      <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(HIST_BINS - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (acc) begin
        rd_q  <= req.rd;
        inc_q <= req.inc;
      end else if (adv) begin
        inc_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      addr_q     <= addr;
      fwd_hit_q  <= we && (waddr == addr);
      fwd_data_q <= wdata;
    end
  end

endmodule

>>> rtl/core/pixel_detector_packet_decoder_top.sv
// Pixel detector readout packet decoder, top level.
// Depends on pdpd_pkg, pdpd_decode, pdpd_hist and pdpd_ram.
//
// Takes one word per clock on the input stream once the histogram clearing
// pass is done: after reset the block clears all HIST_BINS bins, one per
// cycle, and holds s_axis_tready low until the pass is done (config
// writes are taken at any time). A word is decoded in its accept cycle; a
// histogram bin is read in that cycle and written back when its result moves
// to the output register (the next cycle unless the output is stalled), from
// the bin memory's single read and write ports, with the previous update
// forwarded when both touch the same bin. A result reaches the master side
// through the s1 stage register and then the output register; a held
// result stalls the input only when a second result is waiting behind it.
module pixel_detector_packet_decoder_top #(
  parameter int HIST_BINS = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [8:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] stream_word, [75:64] read_index, [79:76] zero
  input  logic [79:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [8:0] hit_x, [17:9] hit_y, [27:18] over_threshold_time,
  // [41:28] arrival_time, [45:42] fine_arrival_time, [75:46] coarse_time,
  // [106:76] flight_time, [138:107] read_value, [143:139] zero
  output logic [143:0] m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]   m_axis_tuser
);

  localparam int AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

  logic [8:0]  roi_x_above;
  logic [8:0]  roi_x_below;
  logic [8:0]  roi_y_above;
  logic [8:0]  roi_y_below;
  logic [12:0] words_left;
  logic [7:0]  chip_number;
  logic [29:0] last_trigger_time;
  logic [31:0] hit_count;
  logic [31:0] header_count;
  logic [31:0] trigger_count;
  logic [31:0] control_count;

  logic [1:0]  action;
  logic [63:0] stream_word;
  logic [11:0] read_index;
  logic [31:0] read_index_ext;
  logic        s_acc;
  logic        in_chunk;
  logic        is_stream;
  logic        is_bin;
  logic        is_cnt;
  logic        pixel_in;
  logic        emits;
  logic        idx_ok;
  logic [31:0] cnt_sel;

  pdpd_pkg::dec_t      dec;
  pdpd_pkg::hist_req_t hreq;
  logic [AW-1:0]       bin_addr;
  logic [AW-1:0]       hist_addr;
  logic [31:0]         hist_value;
  logic                clr_busy;

  logic        s1_valid;
  logic        s1_adv;
  logic [1:0]  s1_kind;
  logic [8:0]  s1_x;
  logic [8:0]  s1_y;
  logic [9:0]  s1_tot;
  logic [13:0] s1_toa;
  logic [3:0]  s1_ftoa;
  logic [29:0] s1_coarse;
  logic [30:0] s1_flight;
  logic [31:0] s1_cnt;
  logic [31:0] s1_value;

  assign action         = s_axis_tuser;
  assign stream_word    = s_axis_tdata[63:0];
  assign read_index     = s_axis_tdata[75:64];
  assign read_index_ext = 32'(read_index);
  assign s_acc          = s_axis_tvalid && s_axis_tready;
  assign in_chunk       = (words_left != 13'd0);
  assign is_stream      = (action == pdpd_pkg::ACT_STREAM);
  assign is_bin         = (action == pdpd_pkg::ACT_BIN);
  assign is_cnt         = (action == pdpd_pkg::ACT_COUNT);
  assign pixel_in       = is_stream && in_chunk && dec.pixel;
  assign emits          = pixel_in || is_bin || is_cnt;
  assign idx_ok         = (read_index_ext < 32'(HIST_BINS));
  assign hreq.inc       = pixel_in && dec.bin_ok;
  assign hreq.rd        = hreq.inc || (is_bin && idx_ok);
  assign hist_addr      = is_bin ? read_index_ext[AW-1:0] : bin_addr;

  assign cfg_ready     = 1'b1;
  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !clr_busy && (!s1_valid || s1_adv);
  assign s1_value      = (s1_kind == pdpd_pkg::KIND_BIN) ? hist_value : s1_cnt;

  always_comb begin
    case (read_index)
      pdpd_pkg::CNT_HITS:     cnt_sel = hit_count;
      pdpd_pkg::CNT_HEADERS:  cnt_sel = header_count;
      pdpd_pkg::CNT_TRIGGERS: cnt_sel = trigger_count;
      pdpd_pkg::CNT_CONTROLS: cnt_sel = control_count;
      default:                cnt_sel = 32'd0;
    endcase
  end

  pdpd_decode #(
    .HIST_BINS(HIST_BINS)
  ) u_decode (
    .word             (stream_word),
    .chip_number      (chip_number),
    .last_trigger_time(last_trigger_time),
    .roi_x_above      (roi_x_above),
    .roi_x_below      (roi_x_below),
    .roi_y_above      (roi_y_above),
    .roi_y_below      (roi_y_below),
    .dec              (dec),
    .bin_addr         (bin_addr)
  );

  pdpd_hist #(
    .HIST_BINS(HIST_BINS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .acc     (s_acc),
    .req     (hreq),
    .addr    (hist_addr),
    .adv     (s1_adv),
    .value   (hist_value),
    .clr_busy(clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_x_above <= pdpd_pkg::ROI_X_ABOVE_RST;
      roi_x_below <= pdpd_pkg::ROI_X_BELOW_RST;
      roi_y_above <= pdpd_pkg::ROI_Y_ABOVE_RST;
      roi_y_below <= pdpd_pkg::ROI_Y_BELOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdpd_pkg::REG_ROI_X_ABOVE: roi_x_above <= cfg_data;
        pdpd_pkg::REG_ROI_X_BELOW: roi_x_below <= cfg_data;
        pdpd_pkg::REG_ROI_Y_ABOVE: roi_y_above <= cfg_data;
        pdpd_pkg::REG_ROI_Y_BELOW: roi_y_below <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left        <= '0;
      chip_number       <= '0;
      last_trigger_time <= '0;
      hit_count         <= '0;
      header_count      <= '0;
      trigger_count     <= '0;
      control_count     <= '0;
    end else if (s_acc && is_stream) begin
      if (in_chunk) begin
        words_left <= words_left - 13'd1;
        if (dec.pixel) begin
          hit_count <= hit_count + 32'd1;
        end else if (dec.trigger) begin
          trigger_count     <= trigger_count + 32'd1;
          last_trigger_time <= dec.trig_time;
        end else if (dec.control) begin
          control_count <= control_count + 32'd1;
        end
      end else if (dec.header) begin
        header_count <= header_count + 32'd1;
        chip_number  <= dec.chip;
        words_left   <= dec.chunk_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc && emits) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      if (is_stream) begin
        s1_kind   <= pdpd_pkg::KIND_HIT;
        s1_x      <= dec.x;
        s1_y      <= dec.y;
        s1_tot    <= dec.tot;
        s1_toa    <= dec.toa;
        s1_ftoa   <= dec.ftoa;
        s1_coarse <= dec.coarse;
        s1_flight <= dec.flight;
        s1_cnt    <= 32'd0;
      end else begin
        s1_kind   <= is_bin ? pdpd_pkg::KIND_BIN : pdpd_pkg::KIND_COUNT;
        s1_x      <= '0;
        s1_y      <= '0;
        s1_tot    <= '0;
        s1_toa    <= '0;
        s1_ftoa   <= '0;
        s1_coarse <= '0;
        s1_flight <= '0;
        s1_cnt    <= is_cnt ? cnt_sel : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tuser <= s1_kind;
      m_axis_tdata <= {5'd0, s1_value, s1_flight, s1_coarse, s1_ftoa, s1_toa,
                       s1_tot, s1_y, s1_x};
    end
  end

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clr_busy |-> !s_axis_tready
  ) else $error("input accepted during histogram clearing pass");

  a_stage_holds: assert property (
    @(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_kind) && $stable(s1_value))
  ) else $error("stalled result changed before it moved to the output");

  a_chunk_countdown: assert property (
    @(posedge clk) disable iff (rst)
    (s_acc && is_stream && in_chunk) |=> (words_left == $past(words_left) - 13'd1)
  ) else $error("chunk word count did not step down");

endmodule
